// ===== sv/mqrf_pkg.sv =====
package mqrf_pkg;

  // Field widths of the transaction payloads
  localparam int unsigned OPCODE_W  = 2;
  localparam int unsigned INTF_W    = 2;
  localparam int unsigned QSEL_W    = 1;
  localparam int unsigned FRAME_W   = 64;
  localparam int unsigned STATUS_W  = 2;
  localparam int unsigned FREE_W    = 4;

  // Largest free count the result field can show
  localparam logic [FREE_W-1:0] FREE_MAX = 4'd15;

  // Operation codes
  localparam logic [OPCODE_W-1:0] OP_PUSH  = 2'd0;
  localparam logic [OPCODE_W-1:0] OP_POP   = 2'd1;
  localparam logic [OPCODE_W-1:0] OP_QUERY = 2'd2;
  localparam logic [OPCODE_W-1:0] OP_CLEAR = 2'd3;

  // Status codes
  localparam logic [STATUS_W-1:0] STAT_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] STAT_FULL  = 2'd1;
  localparam logic [STATUS_W-1:0] STAT_EMPTY = 2'd2;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic accept;    // execute the input transaction this cycle
    logic load_out;  // move the pending result into the output register
  } mqrf_cmd_t;

endpackage

// ===== sv/mqrf_if.sv =====
interface mqrf_in_if;
  import mqrf_pkg::*;

  logic                valid;
  logic                ready;
  logic [OPCODE_W-1:0] opcode;
  logic [INTF_W-1:0]   interface_index;
  logic [QSEL_W-1:0]   queue_index;
  logic [FRAME_W-1:0]  push_frame;

  modport source (output valid, opcode, interface_index, queue_index, push_frame,
                  input ready);
  modport sink   (input valid, opcode, interface_index, queue_index, push_frame,
                  output ready);
endinterface

interface mqrf_out_if;
  import mqrf_pkg::*;

  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [FRAME_W-1:0]  pop_frame;
  logic [FREE_W-1:0]   free_slots;
  logic                is_full;
  logic                is_empty;

  modport source (output valid, status, pop_frame, free_slots, is_full, is_empty,
                  input ready);
  modport sink   (input valid, status, pop_frame, free_slots, is_full, is_empty,
                  output ready);
endinterface

// ===== sv/mqrf_ctrl.sv =====
module mqrf_ctrl
  import mqrf_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  output logic      out_valid,
  input  logic      out_ready,
  output mqrf_cmd_t cmd
);

  // Occupancy of the pending stage and the output register
  localparam logic [1:0] S_IDLE = 2'b00;
  localparam logic [1:0] S_PEND = 2'b01;
  localparam logic [1:0] S_OUT  = 2'b10;
  localparam logic [1:0] S_BOTH = 2'b11;

  logic [1:0] state_r, state_nxt;
  logic       pend_v, out_v, move, acc, take, pend_nxt, out_nxt;

  always_comb begin
    unique case (state_r)
      S_IDLE: begin pend_v = 1'b0; out_v = 1'b0; end
      S_PEND: begin pend_v = 1'b1; out_v = 1'b0; end
      S_OUT:  begin pend_v = 1'b0; out_v = 1'b1; end
      S_BOTH: begin pend_v = 1'b1; out_v = 1'b1; end
      default: begin pend_v = 1'b0; out_v = 1'b0; end
    endcase
  end

  assign take     = out_v && out_ready;
  assign move     = pend_v && (!out_v || out_ready);
  assign in_ready = !pend_v || move;
  assign acc      = in_valid && in_ready;
  assign pend_nxt = acc || (pend_v && !move);
  assign out_nxt  = move || (out_v && !take);

  always_comb begin
    unique case ({out_nxt, pend_nxt})
      2'b00:   state_nxt = S_IDLE;
      2'b01:   state_nxt = S_PEND;
      2'b10:   state_nxt = S_OUT;
      2'b11:   state_nxt = S_BOTH;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign out_valid    = out_v;
  assign cmd.accept   = acc;
  assign cmd.load_out = move;

  a_accept_fills_pend: assert property (@(posedge clk) disable iff (!rst_n)
    acc |=> pend_v)
    else $error("accepted transaction did not reach the pending stage");

  a_out_from_pend: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_v) |-> $past(pend_v))
    else $error("result appeared without a pending transaction");

endmodule

// ===== sv/mqrf_dp.sv =====
module mqrf_dp
  import mqrf_pkg::*;
#(
  parameter int unsigned NUM_INTERFACES       = 4,
  parameter int unsigned QUEUES_PER_INTERFACE = 2,
  parameter int unsigned QUEUE_DEPTH          = 16,
  parameter int unsigned FRAME_WIDTH          = 64
) (
  input  logic                clk,
  input  logic                rst_n,
  input  mqrf_cmd_t           cmd,
  input  logic [OPCODE_W-1:0] opcode,
  input  logic [INTF_W-1:0]   interface_index,
  input  logic [QSEL_W-1:0]   queue_index,
  input  logic [FRAME_W-1:0]  push_frame,
  output logic [STATUS_W-1:0] status,
  output logic [FRAME_W-1:0]  pop_frame,
  output logic [FREE_W-1:0]   free_slots,
  output logic                is_full,
  output logic                is_empty
);

  localparam int unsigned NQ    = NUM_INTERFACES * QUEUES_PER_INTERFACE;
  localparam int unsigned QW    = (NQ > 1) ? $clog2(NQ) : 1;
  localparam int unsigned PW    = $clog2(QUEUE_DEPTH);
  localparam int unsigned AW    = QW + PW;
  localparam int unsigned SLOTS = NQ * QUEUE_DEPTH;

  logic [PW-1:0]          rd_ptr_r [NQ];
  logic [PW-1:0]          wr_ptr_r [NQ];
  logic [FRAME_WIDTH-1:0] frame_mem [SLOTS];
  logic [FRAME_WIDTH-1:0] rd_data_r;

  logic [31:0]       q_wide;
  logic [QW-1:0]     q;
  logic              in_range;
  logic [PW-1:0]     rp, wp, rd_ptr_nxt, wr_ptr_nxt, free_cnt;
  logic              mem_we, mem_re;
  logic [STATUS_W-1:0] stat_c;
  logic [FREE_W-1:0] free_c;

  logic [STATUS_W-1:0] pend_status_r;
  logic [FREE_W-1:0]   pend_free_r;
  logic                pend_full_r, pend_empty_r, pend_pop_r;

  logic [STATUS_W-1:0] out_status_r;
  logic [FRAME_W-1:0]  out_frame_r;
  logic [FREE_W-1:0]   out_free_r;
  logic                out_full_r, out_empty_r;

  // Decode the queue address
  assign q_wide   = 32'(interface_index) * 32'(QUEUES_PER_INTERFACE) + 32'(queue_index);
  assign q        = q_wide[QW-1:0];
  assign in_range = (32'(interface_index) < 32'(NUM_INTERFACES)) &&
                    (32'(queue_index) < 32'(QUEUES_PER_INTERFACE));
  assign rp       = in_range ? rd_ptr_r[q] : '0;
  assign wp       = in_range ? wr_ptr_r[q] : '0;

  always_comb begin
    rd_ptr_nxt = rp;
    wr_ptr_nxt = wp;
    mem_we     = 1'b0;
    mem_re     = 1'b0;
    stat_c     = STAT_OK;
    unique case (opcode)
      OP_PUSH: begin
        if (PW'(wp + 1'b1) == rp) begin
          stat_c = STAT_FULL;
        end else begin
          mem_we     = in_range;
          wr_ptr_nxt = PW'(wp + 1'b1);
        end
      end
      OP_POP: begin
        if (rp == wp) begin
          stat_c = STAT_EMPTY;
        end else begin
          mem_re     = in_range;
          rd_ptr_nxt = PW'(rp + 1'b1);
        end
      end
      OP_CLEAR: begin
        rd_ptr_nxt = '0;
        wr_ptr_nxt = '0;
      end
      default: begin
      end
    endcase
    if (!in_range) begin
      stat_c = STAT_OK;
    end
  end

  assign free_cnt = PW'(rd_ptr_nxt - wr_ptr_nxt - 1'b1);
  assign free_c   = (32'(free_cnt) > 32'(FREE_MAX)) ? FREE_MAX : FREE_W'(free_cnt);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NQ; i++) begin
        rd_ptr_r[i] <= '0;
        wr_ptr_r[i] <= '0;
      end
    end else if (cmd.accept && in_range) begin
      rd_ptr_r[q] <= rd_ptr_nxt;
      wr_ptr_r[q] <= wr_ptr_nxt;
    end
  end

  // Frame store: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (cmd.accept && mem_we) begin
      frame_mem[{q, wp}] <= push_frame[FRAME_WIDTH-1:0];
    end
    if (cmd.accept && mem_re) begin
      rd_data_r <= frame_mem[AW'({q, rp})];
    end
  end

  // Pending result, waits for the read data
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      pend_status_r <= stat_c;
      pend_free_r   <= in_range ? free_c : '0;
      pend_full_r   <= in_range && (free_cnt == '0);
      pend_empty_r  <= in_range && (rd_ptr_nxt == wr_ptr_nxt);
      pend_pop_r    <= mem_re;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_status_r <= pend_status_r;
      out_frame_r  <= pend_pop_r ? FRAME_W'(rd_data_r) : '0;
      out_free_r   <= pend_free_r;
      out_full_r   <= pend_full_r;
      out_empty_r  <= pend_empty_r;
    end
  end

  assign status     = out_status_r;
  assign pop_frame  = out_frame_r;
  assign free_slots = out_free_r;
  assign is_full    = out_full_r;
  assign is_empty   = out_empty_r;

  a_full_excl_empty: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |=> !(out_full_r && out_empty_r))
    else $error("queue reported both full and empty");

  a_failed_pop_zero: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out && (pend_status_r == STAT_EMPTY) |=> (out_frame_r == '0))
    else $error("failed pop returned a nonzero frame");

endmodule

// ===== sv/multi_queue_ring_fifo_top.sv =====
// Bank of ring-buffer frame queues, one per interface and queue number.
// Input channel (in_chan): one transaction names an opcode (push, pop,
// query, clear), an interface index, a queue index and a push frame.
// Result channel (out_chan): exactly one result per input transaction,
// carrying status, popped frame, free slots and full/empty flags of the
// addressed queue after the operation. An address out of range changes
// nothing and returns an all-zero result.
// Result path: an accepted transaction is registered into the pending
// stage while the frame store is read (one registered read port), then
// moves to the output register that drives out_chan.
// Throughput: one transaction per cycle while the consumer takes results;
// pointers update at acceptance, so back-to-back operations on one queue
// see each other.
// Stall: a pending stage and an output register hold up to two results;
// with both occupied, in_chan.ready drops until out_chan.ready returns.
// Reset (synchronous, active low): all read and write pointers go to zero,
// every queue is empty, no result is pending. Frame contents are not
// cleared; only slots pushed since reset or clear are ever popped.
module multi_queue_ring_fifo_top
  import mqrf_pkg::*;
#(
  parameter int unsigned NUM_INTERFACES       = 4,
  parameter int unsigned QUEUES_PER_INTERFACE = 2,
  parameter int unsigned QUEUE_DEPTH          = 16,
  parameter int unsigned FRAME_WIDTH          = 64
) (
  input logic        clk,
  input logic        rst_n,
  mqrf_in_if.sink    in_chan,
  mqrf_out_if.source out_chan
);

  mqrf_cmd_t cmd;

  // Handshake and sequencing
  mqrf_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_chan.valid),
    .in_ready  (in_chan.ready),
    .out_valid (out_chan.valid),
    .out_ready (out_chan.ready),
    .cmd       (cmd)
  );

  // Pointers, frame store and result registers
  mqrf_dp #(
    .NUM_INTERFACES       (NUM_INTERFACES),
    .QUEUES_PER_INTERFACE (QUEUES_PER_INTERFACE),
    .QUEUE_DEPTH          (QUEUE_DEPTH),
    .FRAME_WIDTH          (FRAME_WIDTH)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .opcode          (in_chan.opcode),
    .interface_index (in_chan.interface_index),
    .queue_index     (in_chan.queue_index),
    .push_frame      (in_chan.push_frame),
    .status          (out_chan.status),
    .pop_frame       (out_chan.pop_frame),
    .free_slots      (out_chan.free_slots),
    .is_full         (out_chan.is_full),
    .is_empty        (out_chan.is_empty)
  );

endmodule
